// ----- design/msr_pkg.sv -----
// Shared types and constants for the modular square root block.
// Depends on nothing; every other file imports it.
`default_nettype none
package msr_pkg;
    localparam int RES_W = 32;
    localparam int P_W   = 31;
    localparam int ST_W  = 2;
    localparam int LOG_W = 5;
    localparam int K_W   = 9;

    localparam logic [K_W-1:0]  NR_FIRST  = 9'd2;
    localparam logic [K_W-1:0]  NR_LAST   = 9'd257;
    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_NONRES = 2'd1;
    localparam logic [ST_W-1:0] ST_BOUND  = 2'd2;

    typedef enum logic [1:0] {K_NORM, K_TWO, K_BAD} kind_t;

    typedef struct packed {
        logic [RES_W-1:0] residue;
        logic [P_W-1:0]   prime;
        kind_t            kind;
    } item_t;

    typedef struct packed {
        logic             go;
        logic [RES_W-1:0] a;
        logic [P_W-1:0]   b;
    } mm_req_t;

    typedef enum logic [4:0] {
        B_IDLE, B_RED, B_PW, B_PWMUL, B_PWSQR, B_EULER, B_ROOT3, B_SHIFT,
        B_ZRED, B_ZCHK, B_GOTC, B_GOTT, B_GOTR, B_LOOP, B_ORD, B_ORDW,
        B_BSQ, B_BSQW, B_CW, B_TW, B_RW
    } back_state_t;
endpackage
`default_nettype wire

// ----- design/msr_front.sv -----
// Input stage: registers each transaction and tags the trivial moduli.
// Depends on msr_pkg.
`default_nettype none
module msr_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [31:0]          s_residue,
    input  wire logic [30:0]          s_prime,
    output logic                      push_valid,
    input  wire logic                 push_ready,
    output msr_pkg::item_t            push_item
);
    import msr_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg, item_next;
    kind_t kind;

    always_comb begin
        if (s_prime == 31'd2) begin
            kind = K_TWO;
        end else if (s_prime inside {31'd0, 31'd1}) begin
            kind = K_BAD;
        end else begin
            kind = K_NORM;
        end
    end

    assign s_ready    = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
            item_next  = '{residue: s_residue, prime: s_prime, kind: kind};
        end else if (push_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end
endmodule
`default_nettype wire

// ----- design/msr_fifo.sv -----
// Two-entry queue between the input stage and the sequencer.
// Depends on msr_pkg.
`default_nettype none
module msr_fifo (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  wire msr_pkg::item_t  push_item,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output msr_pkg::item_t       pop_item
);
    import msr_pkg::*;

    item_t       mem [2];
    logic        wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end
endmodule
`default_nettype wire

// ----- design/msr_modmul.sv -----
// Bit-serial modular multiplier: a * b mod p, one bit of a per cycle.
// Requires b < p; a may be any 32-bit value. Depends on msr_pkg.
`default_nettype none
module msr_modmul (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire msr_pkg::mm_req_t     req,
    input  wire logic [30:0]          p,
    output logic                      done,
    output logic [30:0]               res
);
    import msr_pkg::*;

    logic             busy_reg, busy_next, done_reg, done_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic [RES_W-1:0] a_reg, a_next;
    logic [P_W-1:0]   b_reg, b_next, acc_reg, acc_next;
    logic [RES_W-1:0] dbl, dbl_red, sum, sum_red;

    always_comb begin
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, p}) ? dbl - {1'b0, p} : dbl;
        sum     = {1'b0, dbl_red[P_W-1:0]} + (a_reg[RES_W-1] ? {1'b0, b_reg} : '0);
        sum_red = (sum >= {1'b0, p}) ? sum - {1'b0, p} : sum;
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (req.go) begin
            busy_next = 1'b1;
            cnt_next  = 6'(RES_W);
            a_next    = req.a;
            b_next    = req.b;
            acc_next  = '0;
        end else if (busy_reg) begin
            acc_next = sum_red[P_W-1:0];
            a_next   = {a_reg[RES_W-2:0], 1'b0};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign res  = acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end
endmodule
`default_nettype wire

// ----- design/msr_back.sv -----
// Sequencer that runs reduction, Euler's test and Tonelli-Shanks on the
// shared modular multiplier, with the result register. Depends on msr_pkg, msr_modmul.
`default_nettype none
module msr_back #(
    parameter int MOD_BITS = 31
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            pop_valid,
    output logic                 pop_ready,
    input  wire msr_pkg::item_t  pop_item,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic [30:0]          m_root,
    output logic [1:0]           m_status
);
    import msr_pkg::*;

    localparam int CW = $clog2(MOD_BITS + 1);

    back_state_t      state_reg, state_next, ret_reg, ret_next;
    item_t            item_reg, item_next;
    logic [P_W-1:0]   n_reg, n_next, base_reg, base_next, exp_reg, exp_next;
    logic [P_W-1:0]   acc_reg, acc_next, q_reg, q_next, z_reg, z_next;
    logic [P_W-1:0]   c_reg, c_next, t_reg, t_next, r_reg, r_next;
    logic [P_W-1:0]   b_reg, b_next, tmp_reg, tmp_next;
    logic [LOG_W-1:0] s_reg, s_next, m_reg, m_next, j_reg, j_next;
    logic [CW-1:0]    i_reg, i_next;
    logic [K_W-1:0]   k_reg, k_next;
    logic             out_valid_reg, out_valid_next;
    logic [P_W-1:0]   root_reg, root_next;
    logic [ST_W-1:0]  status_reg, status_next;

    mm_req_t          mm_req;
    logic             mm_done;
    logic [P_W-1:0]   mm_res;
    logic             fin;
    logic [P_W-1:0]   fin_root;
    logic [ST_W-1:0]  fin_st;
    logic [P_W-1:0]   p_m1, half_pm1, qtr;
    logic [RES_W-1:0] p_inc;
    logic             pop, i_ge_m, i_cap;

    msr_modmul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mm_req),
        .p       (item_reg.prime),
        .done    (mm_done),
        .res     (mm_res)
    );

    always_comb begin
        p_m1     = item_reg.prime - 31'd1;
        half_pm1 = {1'b0, p_m1[P_W-1:1]};
        p_inc    = {1'b0, item_reg.prime} + 32'd1;
        qtr      = {1'b0, p_inc[RES_W-1:2]};
        i_ge_m   = int'(i_reg) >= int'(m_reg);
        i_cap    = int'(i_reg) >= MOD_BITS;
        pop      = (state_reg == B_IDLE) && pop_valid && (!out_valid_reg || m_ready);
    end

    assign pop_ready = pop;
    assign m_valid   = out_valid_reg;
    assign m_root    = root_reg;
    assign m_status  = status_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: begin
                if (pop && pop_item.kind == K_NORM) state_next = B_RED;
            end
            B_RED: begin
                if (mm_done) state_next = (mm_res == '0) ? B_IDLE : B_PW;
            end
            B_PW: begin
                if (exp_reg == '0) begin
                    state_next = ret_reg;
                end else begin
                    state_next = exp_reg[0] ? B_PWMUL : B_PWSQR;
                end
            end
            B_PWMUL: if (mm_done) state_next = B_PWSQR;
            B_PWSQR: if (mm_done) state_next = B_PW;
            B_EULER: begin
                if (acc_reg != 31'd1) begin
                    state_next = B_IDLE;
                end else if (item_reg.prime[1:0] == 2'b11) begin
                    state_next = B_PW;
                end else begin
                    state_next = B_SHIFT;
                end
            end
            B_ROOT3: state_next = B_IDLE;
            B_SHIFT: if (q_reg[0]) state_next = B_ZRED;
            B_ZRED:  if (mm_done) state_next = B_PW;
            B_ZCHK: begin
                if (acc_reg == p_m1) begin
                    state_next = B_PW;
                end else if (k_reg == NR_LAST) begin
                    state_next = B_IDLE;
                end else begin
                    state_next = B_ZRED;
                end
            end
            B_GOTC: state_next = B_PW;
            B_GOTT: state_next = B_PW;
            B_GOTR: state_next = B_LOOP;
            B_LOOP: state_next = (t_reg == 31'd1) ? B_IDLE : B_ORD;
            B_ORD: begin
                if (tmp_reg == 31'd1) begin
                    state_next = i_ge_m ? B_IDLE : B_BSQ;
                end else begin
                    state_next = i_cap ? B_IDLE : B_ORDW;
                end
            end
            B_ORDW: if (mm_done) state_next = B_ORD;
            B_BSQ:  state_next = (j_reg == '0) ? B_CW : B_BSQW;
            B_BSQW: if (mm_done) state_next = B_BSQ;
            B_CW:   if (mm_done) state_next = B_TW;
            B_TW:   if (mm_done) state_next = B_RW;
            B_RW:   if (mm_done) state_next = B_LOOP;
            default: state_next = B_IDLE;
        endcase
    end

    always_comb begin
        ret_next  = ret_reg;
        item_next = item_reg;
        n_next    = n_reg;
        base_next = base_reg;
        exp_next  = exp_reg;
        acc_next  = acc_reg;
        q_next    = q_reg;
        s_next    = s_reg;
        k_next    = k_reg;
        z_next    = z_reg;
        c_next    = c_reg;
        t_next    = t_reg;
        r_next    = r_reg;
        b_next    = b_reg;
        tmp_next  = tmp_reg;
        m_next    = m_reg;
        i_next    = i_reg;
        j_next    = j_reg;
        mm_req    = '0;
        fin       = 1'b0;
        fin_root  = '0;
        fin_st    = ST_OK;
        case (state_reg)
            B_IDLE: begin
                if (pop) begin
                    item_next = pop_item;
                    case (pop_item.kind)
                        K_TWO: begin
                            fin      = 1'b1;
                            fin_root = {30'd0, pop_item.residue[0]};
                        end
                        K_BAD: begin
                            fin    = 1'b1;
                            fin_st = ST_BOUND;
                        end
                        default: mm_req = '{go: 1'b1, a: pop_item.residue, b: 31'd1};
                    endcase
                end
            end
            B_RED: begin
                if (mm_done) begin
                    n_next = mm_res;
                    if (mm_res == '0) begin
                        fin = 1'b1;
                    end else begin
                        base_next = mm_res;
                        exp_next  = half_pm1;
                        acc_next  = 31'd1;
                        ret_next  = B_EULER;
                    end
                end
            end
            B_PW: begin
                if (exp_reg != '0) begin
                    if (exp_reg[0]) begin
                        mm_req = '{go: 1'b1, a: {1'b0, acc_reg}, b: base_reg};
                    end else begin
                        mm_req = '{go: 1'b1, a: {1'b0, base_reg}, b: base_reg};
                    end
                end
            end
            B_PWMUL: begin
                if (mm_done) begin
                    acc_next = mm_res;
                    mm_req   = '{go: 1'b1, a: {1'b0, base_reg}, b: base_reg};
                end
            end
            B_PWSQR: begin
                if (mm_done) begin
                    base_next = mm_res;
                    exp_next  = {1'b0, exp_reg[P_W-1:1]};
                end
            end
            B_EULER: begin
                if (acc_reg != 31'd1) begin
                    fin    = 1'b1;
                    fin_st = ST_NONRES;
                end else if (item_reg.prime[1:0] == 2'b11) begin
                    base_next = n_reg;
                    exp_next  = qtr;
                    acc_next  = 31'd1;
                    ret_next  = B_ROOT3;
                end else begin
                    q_next = p_m1;
                    s_next = '0;
                end
            end
            B_ROOT3: begin
                fin      = 1'b1;
                fin_root = acc_reg;
            end
            B_SHIFT: begin
                if (!q_reg[0]) begin
                    q_next = {1'b0, q_reg[P_W-1:1]};
                    s_next = s_reg + 5'd1;
                end else begin
                    k_next = NR_FIRST;
                    mm_req = '{go: 1'b1, a: RES_W'(NR_FIRST), b: 31'd1};
                end
            end
            B_ZRED: begin
                if (mm_done) begin
                    z_next    = mm_res;
                    base_next = mm_res;
                    exp_next  = half_pm1;
                    acc_next  = 31'd1;
                    ret_next  = B_ZCHK;
                end
            end
            B_ZCHK: begin
                if (acc_reg == p_m1) begin
                    base_next = z_reg;
                    exp_next  = q_reg;
                    acc_next  = 31'd1;
                    ret_next  = B_GOTC;
                end else if (k_reg == NR_LAST) begin
                    fin    = 1'b1;
                    fin_st = ST_BOUND;
                end else begin
                    k_next = k_reg + 9'd1;
                    mm_req = '{go: 1'b1, a: RES_W'(k_reg + 9'd1), b: 31'd1};
                end
            end
            B_GOTC: begin
                c_next    = acc_reg;
                m_next    = s_reg;
                base_next = n_reg;
                exp_next  = q_reg;
                acc_next  = 31'd1;
                ret_next  = B_GOTT;
            end
            B_GOTT: begin
                t_next    = acc_reg;
                base_next = n_reg;
                exp_next  = {1'b0, q_reg[P_W-1:1]} + 31'd1;
                acc_next  = 31'd1;
                ret_next  = B_GOTR;
            end
            B_GOTR: r_next = acc_reg;
            B_LOOP: begin
                if (t_reg == 31'd1) begin
                    fin      = 1'b1;
                    fin_root = r_reg;
                end else begin
                    tmp_next = t_reg;
                    i_next   = '0;
                end
            end
            B_ORD: begin
                if (tmp_reg == 31'd1) begin
                    if (i_ge_m) begin
                        fin    = 1'b1;
                        fin_st = ST_BOUND;
                    end else begin
                        b_next = c_reg;
                        j_next = LOG_W'(int'(m_reg) - int'(i_reg) - 1);
                    end
                end else if (i_cap) begin
                    fin    = 1'b1;
                    fin_st = ST_BOUND;
                end else begin
                    mm_req = '{go: 1'b1, a: {1'b0, tmp_reg}, b: tmp_reg};
                end
            end
            B_ORDW: begin
                if (mm_done) begin
                    tmp_next = mm_res;
                    i_next   = i_reg + CW'(1);
                end
            end
            B_BSQ: begin
                if (j_reg == '0) begin
                    m_next = LOG_W'(int'(i_reg));
                end
                mm_req = '{go: 1'b1, a: {1'b0, b_reg}, b: b_reg};
            end
            B_BSQW: begin
                if (mm_done) begin
                    b_next = mm_res;
                    j_next = j_reg - 5'd1;
                end
            end
            B_CW: begin
                if (mm_done) begin
                    c_next = mm_res;
                    mm_req = '{go: 1'b1, a: {1'b0, t_reg}, b: mm_res};
                end
            end
            B_TW: begin
                if (mm_done) begin
                    t_next = mm_res;
                    mm_req = '{go: 1'b1, a: {1'b0, r_reg}, b: b_reg};
                end
            end
            B_RW: if (mm_done) r_next = mm_res;
            default: ;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        root_next      = root_reg;
        status_next    = status_reg;
        if (fin) begin
            out_valid_next = 1'b1;
            root_next      = fin_root;
            status_next    = fin_st;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        ret_reg    <= ret_next;
        item_reg   <= item_next;
        n_reg      <= n_next;
        base_reg   <= base_next;
        exp_reg    <= exp_next;
        acc_reg    <= acc_next;
        q_reg      <= q_next;
        s_reg      <= s_next;
        k_reg      <= k_next;
        z_reg      <= z_next;
        c_reg      <= c_next;
        t_reg      <= t_next;
        r_reg      <= r_next;
        b_reg      <= b_next;
        tmp_reg    <= tmp_next;
        m_reg      <= m_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        root_reg   <= root_next;
        status_reg <= status_next;
    end
endmodule
`default_nettype wire

// ----- design/modular_square_root.sv -----
// Modular square root top level: input stage, queue, sequencer.
// Depends on msr_pkg, msr_front, msr_fifo, msr_back.
//
// Each transaction carries a residue and a prime and returns one root with a
// status (0 root found, 1 not a quadratic residue, 2 step bound or bad
// modulus). All arithmetic runs on one bit-serial modular multiplier. A
// modulus of 0, 1 or 2 finishes without using the multiplier, and a residue
// that reduces to zero finishes after the reduction; a prime congruent to 3
// mod 4 takes two exponentiations; other primes add one exponentiation per
// candidate tested, three more for c, t and r, and the squaring loop. Up to
// three transactions can wait in front of the sequencer. A finished result
// waits in its own register, and the sequencer takes the next transaction
// only once that register is empty or being read.
`default_nettype none
module modular_square_root #(
    parameter int MOD_BITS = 31
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_residue,
    input  wire logic [30:0] s_prime,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [30:0]      m_root,
    output logic [1:0]       m_status
);
    import msr_pkg::*;

    logic  push_valid, push_ready, pop_valid, pop_ready;
    item_t push_item, pop_item;

    msr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_residue  (s_residue),
        .s_prime    (s_prime),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    msr_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    msr_back #(
        .MOD_BITS (MOD_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_root    (m_root),
        .m_status  (m_status)
    );
endmodule
`default_nettype wire
